// ----- hdl/pkdd_pkg.sv -----
// Package for the position keyed byte decipher: widths, codes, types and byte functions.
package pkdd_pkg;

  localparam int MAX_KEY_BYTES = 8;
  localparam int BYTE_W        = 8;
  localparam int KEY_W         = MAX_KEY_BYTES * BYTE_W;
  localparam int LEN_W         = 4;
  localparam int POS_W         = 3;
  localparam int ROT_W         = 3;
  localparam int CFG_IDX_W     = 2;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_KEY_BYTES);
  localparam logic [LEN_W-1:0] RST_LEN  = LEN_W'(8);
  localparam logic [7:0]       RST_SHIFT = 8'd47;
  localparam logic [ROT_W-1:0] RST_ROT  = ROT_W'(3);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_BYTES     = 2'd0,
    CFG_KEY_LENGTH    = 2'd1,
    CFG_SHIFT_AMOUNT  = 2'd2,
    CFG_ROTATE_AMOUNT = 2'd3
  } cfg_reg_t;

  // Phase selects the order of the three byte operations
  typedef enum logic [1:0] {
    PH_XSR = 2'd0,   // xor, subtract, rotate
    PH_RXS = 2'd1,   // rotate, xor, subtract
    PH_SRX = 2'd2    // subtract, rotate, xor
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_bytes;
    logic [LEN_W-1:0]  key_length;
    logic [7:0]        shift_amount;
    logic [ROT_W-1:0]  rotate_amount;
  } cfg_t;

  // Contents of the input stage register
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    phase_t            phase;
    logic [BYTE_W-1:0] key;
  } stage_t;

  function automatic logic [7:0] rot_right8(input logic [7:0] v, input logic [ROT_W-1:0] n);
    logic [15:0] dbl;
    dbl = {v, v} >> n;
    return dbl[7:0];
  endfunction

  function automatic logic [7:0] sub_shift(input logic [7:0] v, input logic [7:0] s);
    return v - s;
  endfunction

endpackage

// ----- hdl/position_keyed_byte_decipher_unit.sv -----
// Top level of the position keyed byte decipher: two register stages around the transform.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready  | in_tdata = cipher_byte, in_tlast = last_in
//  out_    | out | out_tvalid/tready | out_tdata = plain_byte, out_tlast = last_out
//  cfg_    | in  | cfg_valid/ready   | cfg_index = register, cfg_data = value
//
// One byte per cycle sustained while out_tready is high; each byte passes the input stage
// register, then the result register, on its way to the output.
// Reset (synchronous, rst_n low) empties both stages, zeroes phase and key position
// and loads the register defaults. A stalled output holds its result while the
// input stage still takes one more byte; configuration writes are always ready.
module position_keyed_byte_decipher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] cipher_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] plain_byte
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pkdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkdd_pkg::KEY_W-1:0]     cfg_data
);

  pkdd_pkg::cfg_t                  cfg;
  pkdd_pkg::phase_t                phase;
  logic [pkdd_pkg::POS_W-1:0]      pos;
  logic [pkdd_pkg::BYTE_W-1:0]     key;
  logic [pkdd_pkg::BYTE_W-1:0]     plain;
  logic                            in_xfer;
  logic                            out_free;
  logic                            s1_move;

  pkdd_pkg::stage_t                s1_r;
  logic                            s1_v_r, s1_v_nxt;
  logic                            out_v_r, out_v_nxt;
  logic [pkdd_pkg::BYTE_W-1:0]     out_data_r;
  logic                            out_last_r;

  assign cfg_ready = 1'b1;

  pkdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pkdd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer),
    .last    (in_tlast),
    .cfg     (cfg),
    .phase   (phase),
    .pos     (pos),
    .key     (key)
  );

  pkdd_xform u_xform (
    .stage         (s1_r),
    .shift_amount  (cfg.shift_amount),
    .rotate_amount (cfg.rotate_amount),
    .plain         (plain)
  );

  // Handshake between the two stages
  assign out_free  = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt  = in_xfer || (s1_v_r && !out_free);
    out_v_nxt = s1_move || (out_v_r && !out_tready);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the input byte with its phase and key byte
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.data  <= in_tdata;
      s1_r.last  <= in_tlast;
      s1_r.phase <= phase;
      s1_r.key   <= key;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= plain;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A last byte restarts both counters
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> phase == pkdd_pkg::PH_XSR && pos == '0)
    else $error("counters not restarted after last byte");

  // The input stage keeps its byte while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_free |=> s1_v_r && $stable(s1_r))
    else $error("input stage lost a byte under stall");

  // Input is refused only when both stages are full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && out_v_r && !out_tready)
    else $error("input refused with free room");

  // A byte moving forward always lands in the result register
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_v_r && out_tlast == $past(s1_r.last))
    else $error("stage transfer lost");

endmodule

// ----- hdl/pkdd_cfg_regs.sv -----
// Configuration registers of the decipher, written through the configuration channel.
module pkdd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [pkdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkdd_pkg::KEY_W-1:0]     cfg_data,
  output pkdd_pkg::cfg_t                 cfg
);

  pkdd_pkg::cfg_t cfg_r;
  pkdd_pkg::cfg_t cfg_nxt;

  // Decode the register index of a write transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (pkdd_pkg::cfg_reg_t'(cfg_index))
        pkdd_pkg::CFG_KEY_BYTES:     cfg_nxt.key_bytes = cfg_data;
        pkdd_pkg::CFG_KEY_LENGTH:    cfg_nxt.key_length = cfg_data[pkdd_pkg::LEN_W-1:0];
        pkdd_pkg::CFG_SHIFT_AMOUNT:  cfg_nxt.shift_amount = cfg_data[7:0];
        pkdd_pkg::CFG_ROTATE_AMOUNT: cfg_nxt.rotate_amount = cfg_data[pkdd_pkg::ROT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_bytes     <= '0;
      cfg_r.key_length    <= pkdd_pkg::RST_LEN;
      cfg_r.shift_amount  <= pkdd_pkg::RST_SHIFT;
      cfg_r.rotate_amount <= pkdd_pkg::RST_ROT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/pkdd_seq.sv -----
// Phase and key position counters, and key byte selection for the current position.
module pkdd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        last,
  input  pkdd_pkg::cfg_t              cfg,
  output pkdd_pkg::phase_t            phase,
  output logic [pkdd_pkg::POS_W-1:0]  pos,
  output logic [pkdd_pkg::BYTE_W-1:0] key
);

  pkdd_pkg::phase_t                phase_r, phase_nxt;
  logic [pkdd_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [pkdd_pkg::LEN_W-1:0]      len_eff;
  logic [pkdd_pkg::LEN_W-1:0]      pos_inc;

  // Clamp key length into one through the key register size
  always_comb begin
    priority if (cfg.key_length == '0) begin
      len_eff = pkdd_pkg::LEN_W'(1);
    end else if (cfg.key_length > pkdd_pkg::MAX_LEN) begin
      len_eff = pkdd_pkg::MAX_LEN;
    end else begin
      len_eff = cfg.key_length;
    end
  end

  // Advance both counters on each input transfer, restart after a last byte
  always_comb begin
    pos_inc   = {1'b0, pos_r} + pkdd_pkg::LEN_W'(1);
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (advance) begin
      if (last) begin
        phase_nxt = pkdd_pkg::PH_XSR;
        pos_nxt   = '0;
      end else begin
        unique case (phase_r)
          pkdd_pkg::PH_XSR: phase_nxt = pkdd_pkg::PH_RXS;
          pkdd_pkg::PH_RXS: phase_nxt = pkdd_pkg::PH_SRX;
          default:          phase_nxt = pkdd_pkg::PH_XSR;
        endcase
        pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[pkdd_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pkdd_pkg::PH_XSR;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign phase = phase_r;
  assign pos   = pos_r;
  assign key   = cfg.key_bytes[{pos_r, 3'b000} +: pkdd_pkg::BYTE_W];

endmodule

// ----- hdl/pkdd_xform.sv -----
// Byte transform: xor, subtract and rotate in the order set by the phase.
module pkdd_xform (
  input  pkdd_pkg::stage_t            stage,
  input  logic [7:0]                  shift_amount,
  input  logic [pkdd_pkg::ROT_W-1:0]  rotate_amount,
  output logic [pkdd_pkg::BYTE_W-1:0] plain
);

  always_comb begin
    unique case (stage.phase)
      pkdd_pkg::PH_RXS: begin
        plain = pkdd_pkg::sub_shift(
                  pkdd_pkg::rot_right8(stage.data, rotate_amount) ^ stage.key, shift_amount);
      end
      pkdd_pkg::PH_SRX: begin
        plain = pkdd_pkg::rot_right8(pkdd_pkg::sub_shift(stage.data, shift_amount),
                                     rotate_amount) ^ stage.key;
      end
      default: begin
        plain = pkdd_pkg::rot_right8(pkdd_pkg::sub_shift(stage.data ^ stage.key, shift_amount),
                                     rotate_amount);
      end
    endcase
  end

endmodule
